/* src/voice_mixer_pan_volume_core_assert.svh */
// Assertion macros for the voice mixer core.
`ifndef VOICE_MIXER_PAN_VOLUME_CORE_ASSERT_SVH
`define VOICE_MIXER_PAN_VOLUME_CORE_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define VMPV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define VMPV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vmpv_pkg.sv */
package vmpv_pkg;

  // Fixed datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 44;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = 51;
  localparam int FIN_W      = 61;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_OUT   = 2'd2;

  localparam logic [GAIN_W-1:0] MASTER_VOL_RST = 16'd4096;

  // Word function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_SL_GAIN,
    MUL_SR_GAIN,
    MUL_PROD_LG,
    MUL_PROD_RG,
    MUL_ACC_LO_L,
    MUL_ACC_HI_L,
    MUL_ACC_LO_R,
    MUL_ACC_HI_R
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD_L,
    ACC_ADD_R,
    ACC_CLEAR
  } acc_op_t;

  typedef enum logic [1:0] {
    FIN_HOLD,
    FIN_LOAD_LO,
    FIN_SIDE_L
  } fin_op_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    fin_op_t  fin_op;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_ML1,
    S_ML2,
    S_MR1,
    S_MR2,
    S_ACCR,
    S_FL0,
    S_FL1,
    S_FR0,
    S_FR1,
    S_OUT
  } state_t;

endpackage

/* src/voice_mixer_pan_volume_core.sv */
// A start word is written straight to the voice store; a sample word for a playing voice runs
//   volume then pan per side on the one 33x18 multiplier, and one for an idle voice skips it.
// A sample word with end_of_frame then adds four master-volume partial products on the same
//   multiplier; the frame word is registered and shows the cycle after.
// Input is taken again while a finished frame word waits on out_ready.
// Reset (synchronous, active low): voices inactive, accumulators zero, enable 0, volume 1.0.
`include "voice_mixer_pan_volume_core_assert.svh"

module voice_mixer_pan_volume_core import vmpv_pkg::*; #(
  parameter int VOICES        = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [3:0]                   in_slot,
  input  logic [23:0]                  in_voice_length,
  input  logic [GAIN_W-1:0]            in_voice_volume,
  input  logic signed [SAMPLE_W-1:0]   in_voice_pan,
  input  logic                         in_voice_is_mono,
  input  logic signed [SAMPLE_W-1:0]   in_sample_left,
  input  logic signed [SAMPLE_W-1:0]   in_sample_right,
  input  logic                         in_end_of_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_left,
  output logic signed [SAMPLE_W-1:0]   out_right,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int REC_W   = 2 * POSITION_BITS + 2 * SAMPLE_W + 1;
  localparam int FRM_TOP = REC_W - 1;
  localparam int POS_TOP = REC_W - POSITION_BITS - 1;
  localparam int GAIN_LO = SAMPLE_W + 1;

  state_t state_r, state_nxt;

  logic                       enable_r, mono_out_r;
  logic [GAIN_W-1:0]          master_vol_r;
  logic                       slot_ok_r, eof_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] samp_l_r, samp_r_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;

  logic                       in_acc, slot_ok_in, start_wr, sample_rd;
  logic [IDX_W-1:0]           in_idx;
  logic [31:0]                len_ext;
  logic [POSITION_BITS-1:0]   start_frames;

  logic                       mem_wr_en, mem_wr_active, mem_rd_en, rd_active;
  logic [IDX_W-1:0]           mem_wr_idx;
  logic [REC_W-1:0]           mem_wr_rec, rd_rec;
  logic [POSITION_BITS-1:0]   rd_frames, rd_pos, pos_inc;
  logic [GAIN_W-1:0]          rd_gain;
  logic signed [SAMPLE_W-1:0] rd_pan;
  logic                       rd_mono, pos_live, voice_go, voice_expire;

  mac_ctl_t                   mac_ctl;
  logic signed [SAMPLE_W-1:0] side_l, side_r, mono_mix;
  logic signed [SAMPLE_W:0]   side_sum;
  logic                       out_free, out_load;

  // Input word decode
  assign in_acc       = in_valid && in_ready;
  assign slot_ok_in   = 32'(in_slot) < 32'(VOICES);
  assign in_idx       = IDX_W'(in_slot);
  assign len_ext      = 32'(in_voice_length);
  assign start_frames = len_ext[POSITION_BITS-1:0];
  assign start_wr     = in_acc && enable_r && (in_func == FUNC_START) && slot_ok_in;
  assign sample_rd    = in_acc && enable_r && (in_func == FUNC_SAMPLE);

  // Voice record fields
  assign rd_frames    = rd_rec[FRM_TOP -: POSITION_BITS];
  assign rd_pos       = rd_rec[POS_TOP -: POSITION_BITS];
  assign rd_gain      = rd_rec[GAIN_LO +: GAIN_W];
  assign rd_pan       = $signed(rd_rec[1 +: SAMPLE_W]);
  assign rd_mono      = rd_rec[0];
  assign pos_live     = rd_pos < rd_frames;
  assign voice_go     = slot_ok_r && rd_active && pos_live;
  assign voice_expire = slot_ok_r && rd_active && !pos_live;
  assign pos_inc      = rd_pos + POSITION_BITS'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      master_vol_r <= MASTER_VOL_RST;
      mono_out_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_MASTER_VOL: master_vol_r <= cfg_data[GAIN_W-1:0];
        CFG_MONO_OUT:   mono_out_r   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Sample word capture
  always_ff @(posedge clk) begin
    if (sample_rd) begin
      samp_l_r  <= in_sample_left;
      samp_r_r  <= in_sample_right;
      eof_r     <= in_end_of_frame;
      slot_ok_r <= slot_ok_in;
      idx_r     <= in_idx;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (sample_rd) state_nxt = S_READ;
      S_READ: begin
        if (voice_go) begin
          state_nxt = S_ML1;
        end else if (eof_r) begin
          state_nxt = S_FL0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ML1:  state_nxt = S_ML2;
      S_ML2:  state_nxt = S_MR1;
      S_MR1:  state_nxt = S_MR2;
      S_MR2:  state_nxt = S_ACCR;
      S_ACCR: state_nxt = eof_r ? S_FL0 : S_IDLE;
      S_FL0:  state_nxt = S_FL1;
      S_FL1:  state_nxt = S_FR0;
      S_FR0:  state_nxt = S_FR1;
      S_FR1:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequencer outputs: datapath control and voice store writes
  always_comb begin
    mac_ctl       = '{mul_en: 1'b0, mul_sel: MUL_SL_GAIN, acc_op: ACC_HOLD, fin_op: FIN_HOLD};
    mem_wr_en     = 1'b0;
    mem_wr_idx    = idx_r;
    mem_wr_rec    = rd_rec;
    mem_wr_active = 1'b0;
    out_load      = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        mem_wr_en     = start_wr;
        mem_wr_idx    = in_idx;
        mem_wr_rec    = {start_frames, {POSITION_BITS{1'b0}}, in_voice_volume,
                         in_voice_pan, in_voice_is_mono};
        mem_wr_active = start_frames != '0;
      end
      S_READ: begin
        // a voice already at its length only drops out
        mem_wr_en = voice_expire;
      end
      S_ML1: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_SL_GAIN;
      end
      S_ML2: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_PROD_LG;
      end
      S_MR1: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_SR_GAIN;
        mac_ctl.acc_op  = ACC_ADD_L;
      end
      S_MR2: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_PROD_RG;
      end
      S_ACCR: begin
        mac_ctl.acc_op = ACC_ADD_R;
        mem_wr_en      = 1'b1;
        mem_wr_rec     = {rd_frames, pos_inc, rd_gain, rd_pan, rd_mono};
        mem_wr_active  = (pos_inc != '0) && (pos_inc < rd_frames);
      end
      S_FL0: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_ACC_LO_L;
      end
      S_FL1: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_ACC_HI_L;
        mac_ctl.fin_op  = FIN_LOAD_LO;
      end
      S_FR0: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_ACC_LO_R;
        mac_ctl.fin_op  = FIN_SIDE_L;
      end
      S_FR1: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_sel = MUL_ACC_HI_R;
        mac_ctl.fin_op  = FIN_LOAD_LO;
      end
      S_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          mac_ctl.acc_op = ACC_CLEAR;
        end
      end
      default: ;
    endcase
  end

  assign mem_rd_en = sample_rd;

  vmpv_voice_mem #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W),
    .REC_W  (REC_W)
  ) u_voice_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (mem_wr_en),
    .wr_idx    (mem_wr_idx),
    .wr_rec    (mem_wr_rec),
    .wr_active (mem_wr_active),
    .rd_en     (mem_rd_en),
    .rd_idx    (in_idx),
    .rd_rec    (rd_rec),
    .rd_active (rd_active)
  );

  vmpv_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .sample_l   (samp_l_r),
    .sample_r   (samp_r_r),
    .mono       (rd_mono),
    .gain       (rd_gain),
    .pan        (rd_pan),
    .master_vol (master_vol_r),
    .side_l     (side_l),
    .side_r     (side_r)
  );

  // Mono mix: floor of the mean of both sides
  assign side_sum = (SAMPLE_W+1)'(side_l) + (SAMPLE_W+1)'(side_r);
  assign mono_mix = side_sum[SAMPLE_W:1];

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= mono_out_r ? mono_mix : side_l;
      out_right_r <= mono_out_r ? mono_mix : side_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  // Checks
  `VMPV_ASSERT_IMP(a_mem_port_excl, clk, rst_n, mem_wr_en, !mem_rd_en, "voice store written and read together")
  `VMPV_ASSERT_IMP(a_out_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_OUT, "frame word loaded outside finish")
  `VMPV_ASSERT_NXT(a_disabled_drop, clk, rst_n, in_acc && !enable_r, state_r == S_IDLE, "word worked on while disabled")
  `VMPV_ASSERT_IMP(a_writeback, clk, rst_n, state_r == S_ACCR, mem_wr_en && !in_ready, "voice position not written back")

endmodule

/* src/vmpv_voice_mem.sv */
module vmpv_voice_mem import vmpv_pkg::*; #(
  parameter int VOICES = 16,
  parameter int IDX_W  = 4,
  parameter int REC_W  = 81
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [REC_W-1:0] wr_rec,
  input  logic             wr_active,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [REC_W-1:0] rd_rec,
  output logic             rd_active
);

  logic [REC_W-1:0] rec_mem [VOICES];
  logic [REC_W-1:0] rd_rec_r;
  logic [VOICES-1:0] active_r;
  logic              rd_active_r;

  // Voice record store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec_r <= rec_mem[rd_idx];
    end
  end

  // Active flags live in flops so reset clears them at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      rd_active_r <= 1'b0;
    end else begin
      if (wr_en) begin
        active_r[wr_idx] <= wr_active;
      end
      if (rd_en) begin
        rd_active_r <= active_r[rd_idx];
      end
    end
  end

  assign rd_rec    = rd_rec_r;
  assign rd_active = rd_active_r;

endmodule

/* src/vmpv_mac.sv */
module vmpv_mac import vmpv_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] sample_l,
  input  logic signed [SAMPLE_W-1:0] sample_r,
  input  logic                       mono,
  input  logic        [GAIN_W-1:0]   gain,
  input  logic signed [SAMPLE_W-1:0] pan,
  input  logic        [GAIN_W-1:0]   master_vol,
  output logic signed [SAMPLE_W-1:0] side_l,
  output logic signed [SAMPLE_W-1:0] side_r
);

  localparam int ACC_SPLIT = 22;
  localparam int Q15_SHIFT = 15;
  localparam int FIN_SHIFT = 24;
  localparam int CON_W     = PROD_W - Q15_SHIFT;
  localparam int SV_W      = FIN_W - FIN_SHIFT;

  localparam logic signed [PROD_W-1:0]  PROD_ROUND = PROD_W'(1) << (Q15_SHIFT - 1);
  localparam logic signed [FIN_W-1:0]   FIN_ROUND  = FIN_W'(1) << (FIN_SHIFT - 1);
  localparam logic signed [MUL_B_W-1:0] UNITY_GAIN = MUL_B_W'(32768);
  localparam logic signed [SV_W-1:0]    SIDE_MAX   = SV_W'(32767);
  localparam logic signed [SV_W-1:0]    SIDE_MIN   = SV_W'(-32768);

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [MUL_B_W-1:0]  pan_x, gain_b, lg_b, rg_b, mv_b;
  logic signed [SAMPLE_W-1:0] sr_eff;
  logic signed [ACC_W-1:0]    acc_l_r, acc_r_r, acc_l_nxt, acc_r_nxt, acc_sel;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [CON_W-1:0]    contrib;
  logic signed [FIN_W-1:0]    fin_r, fin_lo_nxt, fin_total;
  logic signed [SV_W-1:0]     side_v;
  logic signed [SAMPLE_W-1:0] side_l_r, side_sat;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      sat_acc = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_acc = v[ACC_W-1:0];
    end
  endfunction

  // Pan gains: left attenuated for right pan, right for left pan
  assign pan_x  = MUL_B_W'(pan);
  assign gain_b = $signed({2'b00, gain});
  assign mv_b   = $signed({2'b00, master_vol});
  assign lg_b   = (pan > 0) ? (UNITY_GAIN - pan_x) : UNITY_GAIN;
  assign rg_b   = (pan < 0) ? (UNITY_GAIN + pan_x) : UNITY_GAIN;
  assign sr_eff = mono ? sample_l : sample_r;

  // Shared multiplier operand mux
  always_comb begin
    unique case (ctl.mul_sel)
      MUL_SL_GAIN: begin
        mul_a = MUL_A_W'(sample_l);
        mul_b = gain_b;
      end
      MUL_SR_GAIN: begin
        mul_a = MUL_A_W'(sr_eff);
        mul_b = gain_b;
      end
      MUL_PROD_LG: begin
        mul_a = $signed(prod_r[MUL_A_W-1:0]);
        mul_b = lg_b;
      end
      MUL_PROD_RG: begin
        mul_a = $signed(prod_r[MUL_A_W-1:0]);
        mul_b = rg_b;
      end
      MUL_ACC_LO_L: begin
        mul_a = $signed(MUL_A_W'(acc_l_r[ACC_SPLIT-1:0]));
        mul_b = mv_b;
      end
      MUL_ACC_HI_L: begin
        mul_a = MUL_A_W'($signed(acc_l_r[ACC_W-1:ACC_SPLIT]));
        mul_b = mv_b;
      end
      MUL_ACC_LO_R: begin
        mul_a = $signed(MUL_A_W'(acc_r_r[ACC_SPLIT-1:0]));
        mul_b = mv_b;
      end
      MUL_ACC_HI_R: begin
        mul_a = MUL_A_W'($signed(acc_r_r[ACC_W-1:ACC_SPLIT]));
        mul_b = mv_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Pan product back to Q.27, rounded half up, then saturating add
  assign prod_rnd = prod_r + PROD_ROUND;
  assign contrib  = prod_rnd[PROD_W-1:Q15_SHIFT];
  assign acc_sel  = (ctl.acc_op == ACC_ADD_R) ? acc_r_r : acc_l_r;
  assign acc_sum  = (ACC_W+1)'(acc_sel) + (ACC_W+1)'(contrib);

  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    unique case (ctl.acc_op)
      ACC_HOLD:  ;
      ACC_ADD_L: acc_l_nxt = sat_acc(acc_sum);
      ACC_ADD_R: acc_r_nxt = sat_acc(acc_sum);
      ACC_CLEAR: begin
        acc_l_nxt = '0;
        acc_r_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else begin
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
    end
  end

  // Master volume: low partial product plus rounding, then high one shifted in
  assign fin_lo_nxt = FIN_W'(prod_r) + FIN_ROUND;
  assign fin_total  = fin_r + (FIN_W'(prod_r) <<< ACC_SPLIT);
  assign side_v     = $signed(fin_total[FIN_W-1:FIN_SHIFT]);

  always_comb begin
    if (side_v > SIDE_MAX) begin
      side_sat = SIDE_MAX[SAMPLE_W-1:0];
    end else if (side_v < SIDE_MIN) begin
      side_sat = SIDE_MIN[SAMPLE_W-1:0];
    end else begin
      side_sat = side_v[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.fin_op)
      FIN_HOLD:    ;
      FIN_LOAD_LO: fin_r <= fin_lo_nxt;
      FIN_SIDE_L:  side_l_r <= side_sat;
      default:     ;
    endcase
  end

  assign side_l = side_l_r;
  assign side_r = side_sat;

endmodule

/* tb/sv/vmpv_tb_pkg.sv */
`timescale 1ns / 100ps

package vmpv_tb_pkg;
  import vmpv_pkg::*;

  // One word offered on the input channel
  typedef struct {
    logic                       func;
    logic [3:0]                 slot;
    logic [23:0]                length;
    logic [GAIN_W-1:0]          volume;
    logic signed [SAMPLE_W-1:0] pan;
    logic                       is_mono;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       eof;
  } mix_word_t;

  // One mixed output frame
  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } mix_frame_t;

  localparam int     NSLOT     = 16;
  localparam longint SUM_MAX   = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint SUM_MIN   = -SUM_MAX - 1;
  localparam longint POS_MASK  = (longint'(1) << 24) - 1;

  // Mirrors the mixer state and holds the frames still owed by the block
  class mix_frame_board;
    bit         run_en;
    longint     master_gain;
    bit         mono_mix;
    bit         v_on   [NSLOT];
    longint     v_len  [NSLOT];
    longint     v_pos  [NSLOT];
    longint     v_gain [NSLOT];
    longint     v_pan  [NSLOT];
    bit         v_mono [NSLOT];
    longint     sum_l;
    longint     sum_r;
    mix_frame_t frames_due[$];
    int         n_words;
    int         n_starts;
    int         n_frames;
    int         n_errors;

    function new();
      run_en      = 1'b0;
      master_gain = MASTER_VOL_RST;
      mono_mix    = 1'b0;
      sum_l       = 0;
      sum_r       = 0;
      n_words     = 0;
      n_starts    = 0;
      n_frames    = 0;
      n_errors    = 0;
      for (int i = 0; i < NSLOT; i++) begin
        v_on[i]   = 1'b0;
        v_len[i]  = 0;
        v_pos[i]  = 0;
        v_gain[i] = 0;
        v_pan[i]  = 0;
        v_mono[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ENABLE:     run_en = val[0];
        CFG_MASTER_VOL: master_gain = longint'(val);
        CFG_MONO_OUT:   mono_mix = val[0];
        default: ;
      endcase
    endfunction

    // round half up, then drop s fraction bits
    function longint round_drop(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp_sum(longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
    endfunction

    // master gain and Q1.15 saturation of one side
    function longint to_q15(longint acc);
      longint v;
      v = round_drop(acc * master_gain, 24);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void report(string msg);
      n_errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Called for every word the block accepts
    function void take_word(mix_word_t w);
      longint     sl;
      longint     sr;
      longint     lg;
      longint     rg;
      longint     l;
      longint     r;
      longint     m;
      int         k;
      mix_frame_t f;
      if (!run_en) return;
      n_words++;
      k = w.slot;
      if (w.func == FUNC_START) begin
        n_starts++;
        v_len[k]  = longint'(w.length) & POS_MASK;
        v_pos[k]  = 0;
        v_gain[k] = longint'(w.volume);
        v_pan[k]  = longint'(w.pan);
        v_mono[k] = w.is_mono;
        v_on[k]   = (v_len[k] != 0);
        return;
      end
      // sample word: only a playing voice adds into the frame
      if (v_on[k]) begin
        if (v_pos[k] >= v_len[k]) begin
          v_on[k] = 1'b0;
        end else begin
          sl = w.left;
          sr = v_mono[k] ? sl : longint'(w.right);
          lg = (v_pan[k] > 0) ? 32768 - v_pan[k] : 32768;
          rg = (v_pan[k] < 0) ? 32768 + v_pan[k] : 32768;
          sum_l = clamp_sum(sum_l + round_drop(sl * v_gain[k] * lg, 15));
          sum_r = clamp_sum(sum_r + round_drop(sr * v_gain[k] * rg, 15));
          v_pos[k] = (v_pos[k] + 1) & POS_MASK;
          if (v_pos[k] >= v_len[k] || v_pos[k] == 0) v_on[k] = 1'b0;
        end
      end
      if (!w.eof) return;
      l = to_q15(sum_l);
      r = to_q15(sum_r);
      sum_l = 0;
      sum_r = 0;
      if (mono_mix) begin
        m = (l + r) >>> 1;
        l = m;
        r = m;
      end
      f.left  = l[SAMPLE_W-1:0];
      f.right = r[SAMPLE_W-1:0];
      frames_due = {frames_due, f};
    endfunction

    // Called for every frame the block hands over
    function void check_frame(logic signed [SAMPLE_W-1:0] got_l,
                              logic signed [SAMPLE_W-1:0] got_r);
      mix_frame_t f;
      n_frames++;
      if (frames_due.size() == 0) begin
        report($sformatf("frame L=%0d R=%0d with none due", got_l, got_r));
        return;
      end
      f = frames_due.pop_front();
      if (got_l !== f.left)
        report($sformatf("frame %0d left %0d, want %0d", n_frames, got_l, f.left));
      if (got_r !== f.right)
        report($sformatf("frame %0d right %0d, want %0d", n_frames, got_r, f.right));
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void close();
      if (frames_due.size() != 0)
        report($sformatf("%0d frames never came out", frames_due.size()));
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import vmpv_pkg::*;
  import vmpv_tb_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic                       in_func          = FUNC_START;
  logic [3:0]                 in_slot          = '0;
  logic [23:0]                in_voice_length  = '0;
  logic [GAIN_W-1:0]          in_voice_volume  = '0;
  logic signed [SAMPLE_W-1:0] in_voice_pan     = '0;
  logic                       in_voice_is_mono = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample_left   = '0;
  logic signed [SAMPLE_W-1:0] in_sample_right  = '0;
  logic                       in_end_of_frame  = 1'b0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index        = CFG_ENABLE;
  logic [CFG_DATA_W-1:0]      cfg_data         = '0;

  mix_frame_board board;
  bit             hold_req   = 1'b0;
  int             burst_left = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  voice_mixer_pan_volume_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_voice_length  (in_voice_length),
    .in_voice_volume  (in_voice_volume),
    .in_voice_pan     (in_voice_pan),
    .in_voice_is_mono (in_voice_is_mono),
    .in_sample_left   (in_sample_left),
    .in_sample_right  (in_sample_right),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left         (out_left),
    .out_right        (out_right),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Random field values, extremes favoured
  function automatic logic signed [SAMPLE_W-1:0] rand_q15();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 24'($urandom_range(1, 12));
    if (pick < 15) return 24'($urandom_range(13, 300));
    if (pick < 18) return 24'($urandom);
    return 24'd0;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_vol();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return MASTER_VOL_RST;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mix_word_t any_word();
    mix_word_t w;
    w.func    = 1'($urandom_range(0, 1));
    w.slot    = 4'($urandom);
    w.length  = 24'($urandom);
    w.volume  = 16'($urandom);
    w.pan     = rand_q15();
    w.is_mono = 1'($urandom_range(0, 1));
    w.left    = rand_q15();
    w.right   = rand_q15();
    w.eof     = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Start word; the sample fields carry random junk
  function automatic mix_word_t start_word(logic [3:0] slot, logic [23:0] len,
                                           logic [GAIN_W-1:0] vol,
                                           logic signed [SAMPLE_W-1:0] pan,
                                           logic mono, logic eof);
    mix_word_t w;
    w         = any_word();
    w.func    = FUNC_START;
    w.slot    = slot;
    w.length  = len;
    w.volume  = vol;
    w.pan     = pan;
    w.is_mono = mono;
    w.eof     = eof;
    return w;
  endfunction

  // Sample word; the start fields carry random junk
  function automatic mix_word_t sample_word(logic [3:0] slot,
                                            logic signed [SAMPLE_W-1:0] l,
                                            logic signed [SAMPLE_W-1:0] r,
                                            logic eof);
    mix_word_t w;
    w       = any_word();
    w.func  = FUNC_SAMPLE;
    w.slot  = slot;
    w.left  = l;
    w.right = r;
    w.eof   = eof;
    return w;
  endfunction

  // Mostly a playing voice, now and then any slot
  function automatic logic [3:0] pick_slot();
    int live[$];
    for (int i = 0; i < NSLOT; i++)
      if (board.v_on[i]) live = {live, i};
    if (live.size() != 0 && $urandom_range(0, 9) < 8)
      return 4'(live[$urandom_range(0, live.size() - 1)]);
    return 4'($urandom);
  endfunction

  // Sender burst pacing: after a burst, drop valid for a random gap
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Offer one word and hold it until taken
  task automatic send_word(mix_word_t w);
    in_valid         <= 1'b1;
    in_func          <= w.func;
    in_slot          <= w.slot;
    in_voice_length  <= w.length;
    in_voice_volume  <= w.volume;
    in_voice_pan     <= w.pan;
    in_voice_is_mono <= w.is_mono;
    in_sample_left   <= w.left;
    in_sample_right  <= w.right;
    in_end_of_frame  <= w.eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_word(w);
    pace();
  endtask

  // Stop offering, let every owed frame out, then let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic program_regs(logic en, logic [CFG_DATA_W-1:0] mv, logic mono);
    write_reg(CFG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    write_reg(CFG_MASTER_VOL, mv);
    write_reg(CFG_MONO_OUT, {{(CFG_DATA_W-1){1'b0}}, mono});
    cfg_we <= 1'b0;
  endtask

  // Well-formed frames with random content, plus a share of noise words
  task automatic mix_session(int n_items);
    int        done;
    int        samples;
    mix_word_t w;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        w = any_word();
        send_word(w);
        done++;
      end else begin
        repeat ($urandom_range(0, 2)) begin
          send_word(start_word(4'($urandom), rand_len(), rand_vol(), rand_q15(),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          done++;
        end
        samples = $urandom_range(1, 6);
        for (int s = 0; s < samples; s++) begin
          // now and then a frame runs on without its closing flag
          send_word(sample_word(pick_slot(), rand_q15(), rand_q15(),
                                s == samples - 1 && $urandom_range(0, 9) != 0));
          done++;
        end
      end
    end
  endtask

  // Frame monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_frame(out_left, out_right);
  end

  // Receiver stall patterns, plus the long hold-off on request
  initial begin : sink
    sink_mode_t mode;
    int         n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = sink_mode_t'($urandom_range(0, 3));
        n    = $urandom_range(4, 80);
        for (int i = 0; i < n; i++) begin
          case (mode)
            SINK_OPEN:   out_ready <= 1'b1;
            SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: out_ready <= (i % 4 == 3);
            default:     out_ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("[voice_mixer_pan_volume_core] ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_regs(1'b1, MASTER_VOL_RST, 1'b0);

    // centred voice at unity volume
    send_word(start_word(4'd0, 24'd3, 16'd4096, 16'sh0000, 1'b0, 1'b0));
    // mono voice, hard left, loudest volume
    send_word(start_word(4'd15, 24'd2, 16'hFFFF, 16'sh8000, 1'b1, 1'b0));
    // zero length stays idle; its frame flag must be ignored on a start
    send_word(start_word(4'd7, 24'd0, 16'd4096, 16'sh0000, 1'b0, 1'b1));
    // longest voice, hard right
    send_word(start_word(4'd3, 24'hFFFFFF, 16'hFFFF, 16'sh7FFF, 1'b0, 1'b0));
    send_word(sample_word(4'd0, 16'sh7FFF, 16'sh8000, 1'b0));
    send_word(sample_word(4'd15, 16'sh8000, 16'sh3039, 1'b0));
    send_word(sample_word(4'd3, 16'sh8000, 16'sh7FFF, 1'b0));
    // idle slot still closes the frame (output saturates here)
    send_word(sample_word(4'd7, 16'sh1234, 16'sh4321, 1'b1));
    send_word(sample_word(4'd0, 16'shFFFF, 16'sh0001, 1'b1));
    // restart of a playing slot
    send_word(start_word(4'd0, 24'd1, 16'd8192, 16'sh4000, 1'b0, 1'b0));
    send_word(sample_word(4'd0, 16'sh4000, 16'shC000, 1'b1));
    // slot 0 has used up its length
    send_word(sample_word(4'd0, 16'sh7FFF, 16'sh7FFF, 1'b1));
    // slot 15 plays its last sample, then is spent
    send_word(sample_word(4'd15, 16'sh7FFF, 16'sh0000, 1'b0));
    send_word(sample_word(4'd15, 16'sh7FFF, 16'sh0000, 1'b1));
    // zero volume, pan just left of centre
    send_word(start_word(4'd9, 24'd5, 16'd0, 16'shFFFF, 1'b1, 1'b0));
    send_word(sample_word(4'd9, 16'sh7FFF, 16'sh8000, 1'b1));

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_regs(1'b1, MASTER_VOL_RST, 1'b0);
        1: program_regs(1'b1, 16'hFFFF, 1'b1);
        2: program_regs(1'b0, 16'h2000, 1'b0);
        3: program_regs(1'b1, 16'h0000, 1'b0);
        4: program_regs(1'b1, 16'($urandom), 1'b1);
        default: program_regs(1'b1, 16'($urandom_range(0, 8192)), 1'b0);
      endcase
      // back-pressure: receiver holds off while words keep coming
      if (p == 0) hold_req = 1'b1;
      mix_session((p == 2) ? 80 : 340);
    end

    settle();
    board.close();
    $display("run covered %0d words while enabled (%0d voice starts), %0d frames checked",
             board.n_words, board.n_starts, board.n_frames);
    $display("settings: unity, full and zero master gain, stereo and mono mix, disabled");
    if (board.n_errors == 0)
      $display("[voice_mixer_pan_volume_core] OK");
    else
      $display("[voice_mixer_pan_volume_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/vmpv_pkg.sv
src/vmpv_voice_mem.sv
src/vmpv_mac.sv
src/voice_mixer_pan_volume_core.sv
tb/sv/vmpv_tb_pkg.sv
tb/sv/tb_top.sv
